/* rtl/qte_pkg.sv */
`default_nettype none

package qte_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int TABLE_LEN = 24;
  localparam int TW = 36;
  localparam int CW = 38;
  localparam int MAG_W = 28;
  localparam int QUEUE_DEPTH = 4;
  localparam int SQRT_BITS = 29;

  localparam logic signed [TW-1:0] ONE_Q28 = TW'(64'sd268435456);
  localparam logic signed [TW-1:0] NEG_ONE_Q28 = TW'(-64'sd268435456);
  localparam logic [15:0] QUARTER_TURN = 16'h4000;
  localparam logic [15:0] NEG_QUARTER_TURN = 16'hC000;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;
  localparam logic [31:0] ROUND_HALF = 32'h0000_8000;

  typedef struct packed {
    logic signed [TW-1:0] siny;
    logic signed [TW-1:0] cosy;
    logic signed [TW-1:0] sinr;
    logic signed [TW-1:0] cosr;
    logic sat;
    logic neg;
    logic [MAG_W-1:0] mag;
  } item_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] r;
    unique case (idx)
      5'd0: r = 32'd536870912;
      5'd1: r = 32'd316933406;
      5'd2: r = 32'd167458907;
      5'd3: r = 32'd85004756;
      5'd4: r = 32'd42667331;
      5'd5: r = 32'd21354465;
      5'd6: r = 32'd10679838;
      5'd7: r = 32'd5340245;
      5'd8: r = 32'd2670163;
      5'd9: r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41721;
      5'd15: r = 32'd20860;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2607;
      5'd19: r = 32'd1303;
      5'd20: r = 32'd651;
      5'd21: r = 32'd325;
      5'd22: r = 32'd162;
      5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/qte_front.sv */
`default_nettype none

module qte_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic signed [15:0]  quat_w,
  input  wire logic signed [15:0]  quat_x,
  input  wire logic signed [15:0]  quat_y,
  input  wire logic signed [15:0]  quat_z,
  input  wire logic                full,
  output logic                     push,
  output qte_pkg::item_t           item
);

  logic en;
  logic v1;
  logic v2;
  logic signed [31:0] wx, yz, wy, zx, wz, xy, xx, yy, zz;
  logic signed [qte_pkg::TW-1:0] sinr, cosr, sinp, siny, cosy, sinp_abs;
  qte_pkg::item_t item_next;

  assign en = !v2 || !full;
  assign in_stall = !en;
  assign push = v2 && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wx <= quat_w * quat_x;
      yz <= quat_y * quat_z;
      wy <= quat_w * quat_y;
      zx <= quat_z * quat_x;
      wz <= quat_w * quat_z;
      xy <= quat_x * quat_y;
      xx <= quat_x * quat_x;
      yy <= quat_y * quat_y;
      zz <= quat_z * quat_z;
      item <= item_next;
    end
  end

  always_comb begin
    sinr = (qte_pkg::TW'(wx) + qte_pkg::TW'(yz)) <<< 1;
    cosr = qte_pkg::ONE_Q28 - ((qte_pkg::TW'(xx) + qte_pkg::TW'(yy)) <<< 1);
    sinp = (qte_pkg::TW'(wy) - qte_pkg::TW'(zx)) <<< 1;
    siny = (qte_pkg::TW'(wz) + qte_pkg::TW'(xy)) <<< 1;
    cosy = qte_pkg::ONE_Q28 - ((qte_pkg::TW'(yy) + qte_pkg::TW'(zz)) <<< 1);
    sinp_abs = sinp[qte_pkg::TW-1] ? -sinp : sinp;
    item_next.siny = siny;
    item_next.cosy = cosy;
    item_next.sinr = sinr;
    item_next.cosr = cosr;
    item_next.sat = (sinp >= qte_pkg::ONE_Q28) || (sinp <= qte_pkg::NEG_ONE_Q28);
    item_next.neg = sinp[qte_pkg::TW-1];
    item_next.mag = sinp_abs[qte_pkg::MAG_W-1:0];
  end

endmodule

`default_nettype wire

/* rtl/qte_queue.sv */
`default_nettype none

module qte_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire qte_pkg::item_t din,
  output logic                full,
  input  wire logic           pop,
  output qte_pkg::item_t      dout,
  output logic                nonempty
);

  localparam int PW = $clog2(qte_pkg::QUEUE_DEPTH);

  qte_pkg::item_t mem [qte_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0] count;

  assign full = count == (PW+1)'(qte_pkg::QUEUE_DEPTH);
  assign nonempty = count != '0;
  assign dout = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

`default_nettype wire

/* rtl/qte_cordic.sv */
`default_nettype none

module qte_cordic #(
  parameter int STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic signed [qte_pkg::TW-1:0] ys,
  input  wire logic signed [qte_pkg::TW-1:0] xs,
  output logic [15:0]                        ang
);

  logic signed [qte_pkg::CW-1:0] xr [0:STEPS];
  logic signed [qte_pkg::CW-1:0] yr [0:STEPS];
  logic [31:0] acc [0:STEPS];
  logic zr [0:STEPS];
  logic signed [qte_pkg::CW-1:0] xe;
  logic signed [qte_pkg::CW-1:0] ye;
  logic [31:0] rounded;

  assign xe = qte_pkg::CW'(xs);
  assign ye = qte_pkg::CW'(ys);

  always_ff @(posedge clk) begin
    if (en) begin
      zr[0] <= (xs == '0) && (ys == '0);
      if (xs[qte_pkg::TW-1]) begin
        xr[0] <= -xe;
        yr[0] <= -ye;
        acc[0] <= qte_pkg::HALF_TURN;
      end else begin
        xr[0] <= xe;
        yr[0] <= ye;
        acc[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [qte_pkg::CW-1:0] dx;
    logic signed [qte_pkg::CW-1:0] dy;
    assign dx = yr[i] >>> i;
    assign dy = xr[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        zr[i+1] <= zr[i];
        if (!yr[i][qte_pkg::CW-1]) begin
          xr[i+1] <= xr[i] + dx;
          yr[i+1] <= yr[i] - dy;
          acc[i+1] <= acc[i] + qte_pkg::atan_entry(5'(i));
        end else begin
          xr[i+1] <= xr[i] - dx;
          yr[i+1] <= yr[i] + dy;
          acc[i+1] <= acc[i] - qte_pkg::atan_entry(5'(i));
        end
      end
    end
  end

  assign rounded = acc[STEPS] + qte_pkg::ROUND_HALF;
  assign ang = zr[STEPS] ? 16'h0000 : rounded[31:16];

endmodule

`default_nettype wire

/* rtl/qte_back.sv */
`default_nettype none

module qte_back #(
  parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire qte_pkg::item_t head,
  input  wire logic           nonempty,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [15:0]         yaw_angle,
  output logic [15:0]         pitch_angle,
  output logic [15:0]         roll_angle,
  output logic                pitch_saturated
);

  localparam int N = (CORDIC_STEPS > qte_pkg::TABLE_LEN) ? qte_pkg::TABLE_LEN : CORDIC_STEPS;
  localparam int SQ = qte_pkg::SQRT_BITS;
  localparam int PC = SQ + 2;
  localparam int D = PC + N + 1;

  typedef struct packed {
    logic sat;
    logic neg;
    logic [qte_pkg::MAG_W-1:0] mag;
  } side_t;

  logic be;
  logic v [0:D-1];
  side_t sd [0:D-1];
  logic [2*qte_pkg::MAG_W-1:0] magsq;
  logic [2*qte_pkg::MAG_W:0] rem [1:SQ+1];
  logic [SQ-1:0] root [1:SQ+1];
  logic [15:0] yaw_c;
  logic [15:0] roll_c;
  logic [15:0] pitch_c;
  logic [15:0] yaw_d [1:PC];
  logic [15:0] roll_d [1:PC];
  logic signed [qte_pkg::TW-1:0] p_ys;
  logic signed [qte_pkg::TW-1:0] p_xs;
  logic signed [qte_pkg::TW-1:0] mag_ext;

  assign be = !out_valid || !out_stall;
  assign pop = nonempty && be;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < D; p++) begin
        v[p] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (be) begin
      v[0] <= pop;
      for (int p = 1; p < D; p++) begin
        v[p] <= v[p-1];
      end
      out_valid <= v[D-1];
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      sd[0] <= '{sat: head.sat, neg: head.neg, mag: head.mag};
      for (int p = 1; p < D; p++) begin
        sd[p] <= sd[p-1];
      end
      magsq <= head.mag * head.mag;
      rem[1] <= {1'b1, {(2*qte_pkg::MAG_W){1'b0}}} - {1'b0, magsq};
      root[1] <= '0;
    end
  end

  for (genvar p = 2; p <= SQ + 1; p++) begin : g_sqrt
    localparam int B = SQ + 1 - p;
    logic [2*qte_pkg::MAG_W+1:0] trial;
    assign trial = ((2*qte_pkg::MAG_W+2)'(root[p-1]) << (B + 1))
                 + ((2*qte_pkg::MAG_W+2)'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (be) begin
        if ({1'b0, rem[p-1]} >= trial) begin
          rem[p] <= rem[p-1] - trial[2*qte_pkg::MAG_W:0];
          root[p] <= root[p-1] | (SQ'(1) << B);
        end else begin
          rem[p] <= rem[p-1];
          root[p] <= root[p-1];
        end
      end
    end
  end

  assign mag_ext = qte_pkg::TW'(sd[PC-1].mag);
  assign p_ys = sd[PC-1].neg ? -mag_ext : mag_ext;
  assign p_xs = qte_pkg::TW'(root[SQ+1]);

  qte_cordic #(.STEPS(N)) u_yaw (
    .clk (clk),
    .en  (be),
    .ys  (head.siny),
    .xs  (head.cosy),
    .ang (yaw_c)
  );

  qte_cordic #(.STEPS(N)) u_roll (
    .clk (clk),
    .en  (be),
    .ys  (head.sinr),
    .xs  (head.cosr),
    .ang (roll_c)
  );

  qte_cordic #(.STEPS(N)) u_pitch (
    .clk (clk),
    .en  (be),
    .ys  (p_ys),
    .xs  (p_xs),
    .ang (pitch_c)
  );

  always_ff @(posedge clk) begin
    if (be) begin
      yaw_d[1] <= yaw_c;
      roll_d[1] <= roll_c;
      for (int j = 2; j <= PC; j++) begin
        yaw_d[j] <= yaw_d[j-1];
        roll_d[j] <= roll_d[j-1];
      end
      yaw_angle <= yaw_d[PC];
      roll_angle <= roll_d[PC];
      pitch_saturated <= sd[D-1].sat;
      if (sd[D-1].sat) begin
        pitch_angle <= sd[D-1].neg ? qte_pkg::NEG_QUARTER_TURN : qte_pkg::QUARTER_TURN;
      end else begin
        pitch_angle <= pitch_c;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/quaternion_to_euler_angles_unit.sv */
`default_nettype none

// channel | handshake            | payload
// input   | in_valid / in_stall  | quat_w, quat_x, quat_y, quat_z
// output  | out_valid / out_stall| yaw_angle, pitch_angle, roll_angle, pitch_saturated
//
// One request enters per cycle and one result leaves per cycle when unstalled.
// The path runs through two product/sum stages, a queue slot, a
// 31-stage square-root path for the pitch cosine, the pitch CORDIC, and the output register.
// Reset clears all valid state and the queue; payload registers are not reset.
// A stalled output freezes the back pipeline; the four-entry queue lets the front keep taking
// requests until it fills, then in_stall rises.

module quaternion_to_euler_angles_unit #(
  parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] quat_w,
  input  wire logic signed [15:0] quat_x,
  input  wire logic signed [15:0] quat_y,
  input  wire logic signed [15:0] quat_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      yaw_angle,
  output logic signed [15:0]      pitch_angle,
  output logic signed [15:0]      roll_angle,
  output logic                    pitch_saturated
);

  logic full;
  logic push;
  logic pop;
  logic nonempty;
  qte_pkg::item_t f_item;
  qte_pkg::item_t q_item;
  logic [15:0] yaw_u;
  logic [15:0] pitch_u;
  logic [15:0] roll_u;

  qte_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .quat_w   (quat_w),
    .quat_x   (quat_x),
    .quat_y   (quat_y),
    .quat_z   (quat_z),
    .full     (full),
    .push     (push),
    .item     (f_item)
  );

  qte_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .din      (f_item),
    .full     (full),
    .pop      (pop),
    .dout     (q_item),
    .nonempty (nonempty)
  );

  qte_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (q_item),
    .nonempty        (nonempty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .yaw_angle       (yaw_u),
    .pitch_angle     (pitch_u),
    .roll_angle      (roll_u),
    .pitch_saturated (pitch_saturated)
  );

  assign yaw_angle = signed'(yaw_u);
  assign pitch_angle = signed'(pitch_u);
  assign roll_angle = signed'(roll_u);

endmodule

`default_nettype wire
